// ----- src/whrq_pkg.sv -----
// whrq_pkg: shared constants, state type and controller/datapath link types
`timescale 1ns / 1ps
package whrq_pkg;

  localparam int CAPACITY     = 4096;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = IDX_W + 1;
  localparam int METRIC_COUNT = 7;
  localparam int MI_W         = 3;
  localparam int WORD_W       = 32;
  localparam int ROW_W        = METRIC_COUNT * WORD_W;
  localparam int MAX_RESULTS  = 64;
  localparam int LIM_W        = 7;
  localparam int RES_AW       = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W    = RES_AW + 1;
  localparam int NUM_W        = CNT_W + 1;
  localparam int DIV_CW       = $clog2(NUM_W + 1);

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_DIV,
    S_SELECT,
    S_FIX,
    S_EMIT_RD,
    S_EMIT_LD,
    S_NOMATCH
  } whrq_state_t;

  typedef struct packed {
    logic add_wr;
    logic load_q;
    logic walk_start;
    logic walk_en;
    logic sel_pass;
    logic div_start;
    logic fix;
    logic emit_rd;
    logic emit_ld;
    logic nomatch_ld;
  } whrq_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic no_match;
    logic div_done;
    logic out_free;
    logic emit_last;
  } whrq_stat_t;

endpackage

// ----- src/whrq_if.sv -----
// whrq_if: input and result channel interfaces
`timescale 1ns / 1ps
interface whrq_in_if import whrq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [WORD_W-1:0]   time_ms;
  logic [WORD_W-1:0]   pm25;
  logic [WORD_W-1:0]   co2;
  logic [WORD_W-1:0]   temperature;
  logic [WORD_W-1:0]   humidity;
  logic [WORD_W-1:0]   tvoc;
  logic [WORD_W-1:0]   nox;
  logic [WORD_W-1:0]   aqi;
  logic [MI_W-1:0]     metric;
  logic [WORD_W-1:0]   window_ms;
  logic [LIM_W-1:0]    max_out;

  modport source (output valid, action, time_ms, pm25, co2, temperature, humidity, tvoc,
                  nox, aqi, metric, window_ms, max_out, input ready);
  modport sink   (input valid, action, time_ms, pm25, co2, temperature, humidity, tvoc,
                  nox, aqi, metric, window_ms, max_out, output ready);
endinterface

interface whrq_out_if import whrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic [WORD_W-1:0] age_ms;
  logic              valid_res;
  logic              last;

  modport source (output valid, value, age_ms, valid_res, last, input ready);
  modport sink   (input valid, value, age_ms, valid_res, last, output ready);
endinterface

// ----- src/whrq_ctrl.sv -----
// whrq_ctrl: sequencing state machine for add and query items
`timescale 1ns / 1ps
module whrq_ctrl import whrq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_action,
  output logic       in_ready,
  input  whrq_stat_t stat,
  output whrq_cmd_t  cmd
);

  whrq_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_ADD) begin
            cmd.add_wr = 1'b1;
          end else begin
            cmd.load_q     = 1'b1;
            cmd.walk_start = 1'b1;
            state_nxt      = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        cmd.walk_en = 1'b1;
        if (stat.walk_done) begin
          if (stat.no_match) begin
            state_nxt = S_NOMATCH;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd.walk_en  = 1'b1;
        cmd.sel_pass = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        if (stat.out_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = stat.emit_last ? S_IDLE : S_EMIT_RD;
      end
      S_NOMATCH: begin
        if (stat.out_free) begin
          cmd.nomatch_ld = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- src/whrq_dp.sv -----
// whrq_dp: record stores, ring walk, stride divider, result buffer and output register
`timescale 1ns / 1ps
module whrq_dp import whrq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  whrq_in_if.sink    in_ch,
  whrq_out_if.source out_ch,
  input  whrq_cmd_t  cmd,
  output whrq_stat_t stat
);

  // record stores, one row per slot
  logic [WORD_W-1:0] tmem [CAPACITY];
  logic [ROW_W-1:0]  mmem [CAPACITY];
  logic [2*WORD_W-1:0] rmem [MAX_RESULTS];

  logic [IDX_W-1:0]  head_r, start_r;
  logic [CNT_W-1:0]  count_r, i_r, matches_r, stride_r, phase_r;
  logic              rd_vld_r;
  logic [WORD_W-1:0] tq_r;
  logic [ROW_W-1:0]  mq_r;
  logic [WORD_W-1:0] now_r, win_r;
  logic [MI_W-1:0]   mi_r;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [RES_CNT_W-1:0] n_r, e_r;
  logic [WORD_W-1:0] new_val_r, new_age_r, emit_age_r;
  logic [2*WORD_W-1:0] rq_r;
  logic [NUM_W-1:0]  num_r;
  logic [LIM_W-1:0]  rem_r;
  logic [DIV_CW-1:0] div_cnt_r;
  logic              out_vld_r, vres_r, last_r;
  logic [WORD_W-1:0] value_r, age_r;

  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en, hit, take;
  logic [WORD_W-1:0] age, sel_val;
  logic [LIM_W:0]    trial;
  logic              res_we;
  logic [RES_AW-1:0] res_wa;
  logic [2*WORD_W-1:0] res_wd;
  logic              fix_need;

  // query limit clamp
  always_comb begin
    priority if (in_ch.max_out == '0) begin
      lim_nxt = LIM_W'(1);
    end else if (in_ch.max_out > LIM_W'(MAX_RESULTS)) begin
      lim_nxt = LIM_W'(MAX_RESULTS);
    end else begin
      lim_nxt = in_ch.max_out;
    end
  end

  // walk read address and window test
  assign rd_addr = start_r + i_r[IDX_W-1:0];
  assign rd_en   = cmd.walk_en && (i_r != count_r);
  assign age     = now_r - tq_r;
  assign hit     = rd_vld_r && ((win_r == '0) || (age <= win_r));
  assign sel_val = (32'(mi_r) < METRIC_COUNT) ? mq_r[int'(mi_r)*WORD_W +: WORD_W] : '0;
  assign take    = hit && cmd.sel_pass && (phase_r == '0) && (n_r < RES_CNT_W'(lim_r));
  assign fix_need = (n_r != '0) && (new_age_r != emit_age_r);

  // store writes and walk reads
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      tmem[head_r] <= in_ch.time_ms;
      mmem[head_r] <= {in_ch.aqi, in_ch.nox, in_ch.tvoc, in_ch.humidity,
                       in_ch.temperature, in_ch.co2, in_ch.pm25};
    end
    if (rd_en) begin
      tq_r <= tmem[rd_addr];
      mq_r <= mmem[rd_addr];
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.add_wr) begin
      head_r <= head_r + 1'b1;
      if (count_r != CNT_W'(CAPACITY)) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // query fields
  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      now_r   <= in_ch.time_ms;
      win_r   <= in_ch.window_ms;
      mi_r    <= in_ch.metric;
      lim_r   <= lim_nxt;
      start_r <= head_r - count_r[IDX_W-1:0];
    end
  end

  // walk counter and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      i_r      <= '0;
    end else if (cmd.walk_start) begin
      rd_vld_r <= 1'b0;
      i_r      <= '0;
    end else begin
      rd_vld_r <= rd_en;
      if (rd_en) begin
        i_r <= i_r + 1'b1;
      end
    end
  end

  // match count and selection pass
  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      matches_r <= '0;
    end else if (hit && !cmd.sel_pass) begin
      matches_r <= matches_r + 1'b1;
    end
    if (cmd.walk_start) begin
      phase_r <= '0;
    end else if (hit && cmd.sel_pass) begin
      new_val_r <= sel_val;
      new_age_r <= age;
      phase_r   <= (phase_r + 1'b1 == stride_r) ? '0 : phase_r + 1'b1;
    end
    if (take) begin
      emit_age_r <= age;
    end
  end

  // result count and emit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      e_r <= '0;
    end else begin
      if (cmd.load_q) begin
        n_r <= '0;
      end else if (take || (cmd.fix && fix_need && (n_r < RES_CNT_W'(lim_r)))) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.fix) begin
        e_r <= '0;
      end else if (cmd.emit_ld) begin
        e_r <= e_r + 1'b1;
      end
    end
  end

  // result buffer write port
  always_comb begin
    res_we = take;
    res_wa = n_r[RES_AW-1:0];
    res_wd = {sel_val, age};
    if (cmd.fix) begin
      res_we = fix_need;
      res_wd = {new_val_r, new_age_r};
      res_wa = (n_r < RES_CNT_W'(lim_r)) ? n_r[RES_AW-1:0] : RES_AW'(n_r - 1'b1);
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (res_we) begin
      rmem[res_wa] <= res_wd;
    end
    if (cmd.emit_rd) begin
      rq_r <= rmem[e_r[RES_AW-1:0]];
    end
  end

  // stride divider, one quotient bit per cycle
  assign trial = {rem_r, num_r[NUM_W-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      num_r     <= NUM_W'(matches_r) + NUM_W'(lim_r) - 1'b1;
      rem_r     <= '0;
      div_cnt_r <= DIV_CW'(NUM_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
      if (trial >= {1'b0, lim_r}) begin
        rem_r <= LIM_W'(trial - {1'b0, lim_r});
        num_r <= {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[LIM_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk) begin
    if ((div_cnt_r == DIV_CW'(1)) && !cmd.div_start) begin
      stride_r <= (trial >= {1'b0, lim_r}) ? CNT_W'({num_r[NUM_W-2:0], 1'b1})
                                            : CNT_W'({num_r[NUM_W-2:0], 1'b0});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit_ld || cmd.nomatch_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (cmd.emit_ld) begin
      value_r <= rq_r[2*WORD_W-1:WORD_W];
      age_r   <= rq_r[WORD_W-1:0];
      vres_r  <= 1'b1;
      last_r  <= (e_r + 1'b1 == n_r);
    end else if (cmd.nomatch_ld) begin
      value_r <= '0;
      age_r   <= '0;
      vres_r  <= 1'b0;
      last_r  <= 1'b1;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.value     = value_r;
  assign out_ch.age_ms    = age_r;
  assign out_ch.valid_res = vres_r;
  assign out_ch.last      = last_r;

  // status to controller
  assign stat.walk_done = (i_r == count_r) && !rd_vld_r;
  assign stat.no_match  = (matches_r == '0);
  assign stat.div_done  = (div_cnt_r == '0);
  assign stat.out_free  = !out_vld_r || out_ch.ready;
  assign stat.emit_last = (e_r + 1'b1 == n_r);

endmodule

// ----- src/windowed_history_ring_query.sv -----
// windowed_history_ring_query: top level of the timestamped history ring
//
//  channel   role     transfer
//  in_ch     sink     add record (action 0) or query (action 1)
//  out_ch    source   value, age_ms, valid_res, last per result
//
// add: taken in the idle state
// query: run time set by the two walks through the single read port of the
//   record stores, the one-bit-per-cycle stride divider and the sink's ready
// reset clears head, count and control state; stores hold whatever was last written
// a stalled result holds the query in the emit state; adds may be taken
//   while the final result still waits
`timescale 1ns / 1ps
module windowed_history_ring_query import whrq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  whrq_in_if.sink    in_ch,
  whrq_out_if.source out_ch
);

  whrq_cmd_t  cmd;
  whrq_stat_t stat;

  // controller
  whrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  whrq_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ----- tb/whrq_tb_if.sv -----
// whrq_tb_if: the testbench uses the channel interfaces of the design sources
`timescale 1ns / 1ps

// ----- tb/testbench.sv -----
// testbench: random and directed adds and queries checked against a ring predictor
`timescale 1ns / 1ps
module testbench;
  import whrq_pkg::*;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] time_ms;
    logic [ROW_W-1:0]  metrics;
    logic [MI_W-1:0]   metric;
    logic [WORD_W-1:0] window_ms;
    logic [LIM_W-1:0]  max_out;
  } ring_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] age_ms;
    logic              valid_res;
    logic              last;
  } sample_t;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  whrq_in_if  in_ch ();
  whrq_out_if out_ch ();

  windowed_history_ring_query dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // ring mirror
  logic [WORD_W-1:0] ring_time [CAPACITY];
  logic [ROW_W-1:0]  ring_row  [CAPACITY];
  int unsigned       ring_head;
  int unsigned       ring_count;

  ring_op_t    pending_ops [$];
  sample_t     expected_samples [$];
  int unsigned errors;
  int unsigned cycles;
  bit          hold_sender;
  bit          stim_done;
  int unsigned send_gap;
  int unsigned take_gap;

  function automatic logic [WORD_W-1:0] pick_word(logic [ROW_W-1:0] row, int unsigned mi);
    logic [WORD_W-1:0] w;
    w = '0;
    if (mi < METRIC_COUNT) w = row[mi*WORD_W +: WORD_W];
    return w;
  endfunction

  function automatic bit in_span(logic [WORD_W-1:0] t, logic [WORD_W-1:0] now,
                                 logic [WORD_W-1:0] win);
    logic [WORD_W-1:0] age;
    age = now - t;
    return (win == 0) || (age <= win);
  endfunction

  // apply one accepted transfer to the mirror and queue its results
  task automatic predict_ring(ring_op_t op);
    int unsigned start, slot, match_cnt, stride, seen, n, lim, last_slot;
    logic [WORD_W-1:0] vals [MAX_RESULTS];
    logic [WORD_W-1:0] ages [MAX_RESULTS];
    logic [WORD_W-1:0] newest;
    sample_t s;
    match_cnt = 0; seen = 0; n = 0; last_slot = 0;
    if (op.action == ACT_ADD) begin
      ring_time[ring_head] = op.time_ms;
      ring_row[ring_head] = op.metrics;
      ring_head = (ring_head + 1) % CAPACITY;
      if (ring_count < CAPACITY) ring_count++;
      return;
    end
    lim = op.max_out;
    if (lim == 0) lim = 1;
    if (lim > MAX_RESULTS) lim = MAX_RESULTS;
    start = (ring_head + CAPACITY - ring_count) % CAPACITY;
    for (int unsigned i = 0; i < ring_count; i++)
      if (in_span(ring_time[(start + i) % CAPACITY], op.time_ms, op.window_ms)) match_cnt++;
    if (match_cnt == 0) begin
      s = '{value: '0, age_ms: '0, valid_res: 1'b0, last: 1'b1};
      expected_samples.push_back(s);
      return;
    end
    stride = (match_cnt + lim - 1) / lim;
    for (int unsigned i = 0; i < ring_count; i++) begin
      slot = (start + i) % CAPACITY;
      if (!in_span(ring_time[slot], op.time_ms, op.window_ms)) continue;
      last_slot = slot;
      if (seen % stride == 0 && n < lim) begin
        vals[n] = pick_word(ring_row[slot], op.metric);
        ages[n] = op.time_ms - ring_time[slot];
        n++;
      end
      seen++;
    end
    newest = op.time_ms - ring_time[last_slot];
    if (ages[n-1] != newest) begin
      if (n < lim) n++;
      vals[n-1] = pick_word(ring_row[last_slot], op.metric);
      ages[n-1] = newest;
    end
    for (int unsigned k = 0; k < n; k++) begin
      s = '{value: vals[k], age_ms: ages[k], valid_res: 1'b1, last: (k + 1 == n)};
      expected_samples.push_back(s);
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic ring_op_t make_add(logic [WORD_W-1:0] t);
    ring_op_t op;
    op.action = ACT_ADD;
    op.time_ms = t;
    for (int k = 0; k < METRIC_COUNT; k++) op.metrics[k*WORD_W +: WORD_W] = $urandom;
    op.metric = MI_W'($urandom);
    op.window_ms = $urandom;
    op.max_out = LIM_W'($urandom);
    return op;
  endfunction

  function automatic ring_op_t make_query(logic [WORD_W-1:0] now, logic [WORD_W-1:0] win,
                                          logic [MI_W-1:0] mi, logic [LIM_W-1:0] lim);
    ring_op_t op;
    op = make_add(now);
    op.action = ACT_QUERY;
    op.metric = mi;
    op.window_ms = win;
    op.max_out = lim;
    return op;
  endfunction

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the offered transfer
    end else if (send_gap != 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_ops.size() != 0 && !hold_sender) begin
      ring_op_t op;
      op = pending_ops.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.action <= op.action;
      in_ch.time_ms <= op.time_ms;
      in_ch.pm25 <= op.metrics[0*WORD_W +: WORD_W];
      in_ch.co2 <= op.metrics[1*WORD_W +: WORD_W];
      in_ch.temperature <= op.metrics[2*WORD_W +: WORD_W];
      in_ch.humidity <= op.metrics[3*WORD_W +: WORD_W];
      in_ch.tvoc <= op.metrics[4*WORD_W +: WORD_W];
      in_ch.nox <= op.metrics[5*WORD_W +: WORD_W];
      in_ch.aqi <= op.metrics[6*WORD_W +: WORD_W];
      in_ch.metric <= op.metric;
      in_ch.window_ms <= op.window_ms;
      in_ch.max_out <= op.max_out;
      send_gap <= draw_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // accepted input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      ring_op_t op;
      op.action = in_ch.action;
      op.time_ms = in_ch.time_ms;
      op.metrics = {in_ch.aqi, in_ch.nox, in_ch.tvoc, in_ch.humidity,
                    in_ch.temperature, in_ch.co2, in_ch.pm25};
      op.metric = in_ch.metric;
      op.window_ms = in_ch.window_ms;
      op.max_out = in_ch.max_out;
      predict_ring(op);
    end
  end

  // monitor and result-side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sample_t got, want;
        got = '{value: out_ch.value, age_ms: out_ch.age_ms,
                valid_res: out_ch.valid_res, last: out_ch.last};
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, got.value);
            errors++;
          end
          if (got.age_ms !== want.age_ms) begin
            $display("%0t: age_ms expected %h actual %h", $time, want.age_ms, got.age_ms);
            errors++;
          end
          if (got.valid_res !== want.valid_res) begin
            $display("%0t: valid_res expected %b actual %b", $time, want.valid_res,
                     got.valid_res);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if (take_gap != 0) begin
        out_ch.ready <= 1'b0;
        take_gap <= take_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        take_gap <= draw_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [WORD_W-1:0] now;
    ring_op_t op;
    errors = 0;
    cycles = 0;
    hold_sender = 1'b0;
    ring_head = 0;
    ring_count = 0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.time_ms = '0;
    in_ch.pm25 = '0;
    in_ch.co2 = '0;
    in_ch.temperature = '0;
    in_ch.humidity = '0;
    in_ch.tvoc = '0;
    in_ch.nox = '0;
    in_ch.aqi = '0;
    in_ch.metric = '0;
    in_ch.window_ms = '0;
    in_ch.max_out = '0;
    out_ch.ready = 1'b0;

    // directed: empty ring, limit extremes, wrap of age, equal ages, bad metric
    pending_ops.push_back(make_query(32'd100, 32'd0, 3'd0, 7'd1));
    pending_ops.push_back(make_add(32'hFFFF_FFF0));
    op = make_add(32'd5);
    op.metrics = '1;
    pending_ops.push_back(op);
    op = make_add(32'd5);
    op.metrics = '0;
    pending_ops.push_back(op);
    pending_ops.push_back(make_add(32'd20));
    pending_ops.push_back(make_query(32'd30, 32'd0, 3'd6, 7'd0));
    pending_ops.push_back(make_query(32'd30, 32'd0, 3'd7, 7'd64));
    pending_ops.push_back(make_query(32'd30, 32'd25, 3'd1, 7'd127));
    pending_ops.push_back(make_query(32'd30, 32'd10, 3'd2, 7'd2));
    pending_ops.push_back(make_query(32'd30, 32'd1, 3'd3, 7'd3));
    pending_ops.push_back(make_query(32'd30, 32'hFFFF_FFFF, 3'd4, 7'd2));
    pending_ops.push_back(make_query(32'hFFFF_FFFF, 32'd0, 3'd5, 7'd1));
    for (int i = 0; i < 6; i++) pending_ops.push_back(make_add(32'd40 + i));
    pending_ops.push_back(make_query(32'd50, 32'd0, 3'd0, 7'd3));
    pending_ops.push_back(make_query(32'd50, 32'd9, 3'd1, 7'd4));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // pause the sender until every queued result is back
    wait (pending_ops.size() == 0 && !in_ch.valid);
    hold_sender = 1'b1;
    wait (expected_samples.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;

    // random: adds with rising time interleaved with queries over them
    now = $urandom;
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(0, 99) < 65) begin
        now = now + $urandom_range(0, 50);
        pending_ops.push_back(make_add(now));
      end else if ($urandom_range(0, 9) == 0) begin
        pending_ops.push_back(make_query($urandom, $urandom, MI_W'($urandom),
                                         LIM_W'($urandom)));
      end else begin
        pending_ops.push_back(make_query(now + $urandom_range(0, 30),
                                         $urandom_range(0, 3) == 0 ? 32'd0
                                                                   : $urandom_range(0, 400),
                                         MI_W'($urandom), LIM_W'($urandom_range(0, 70))));
      end
    end

    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_samples.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
